// File: src/assert_macros.svh
// assertion macros used by the arp cache rtl file
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: src/arpc_pkg.sv
// types, codes and reset constants of the arp cache
// no dependencies
package arpc_pkg;

    localparam int TABLE_DEPTH = 8;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int TTL_W    = 16;
    localparam int RETRY_W  = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int EIDX_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_RESOLVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEARN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NEW_REQ   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_PENDING   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LEARNED   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_RETRY_REQ = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_TICK_DONE = 3'd6;

    // entry state codes
    localparam logic [1:0] ENT_FREE    = 2'd0;
    localparam logic [1:0] ENT_PENDING = 2'd1;
    localparam logic [1:0] ENT_VALID   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIFETIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd3;

    localparam logic [TTL_W-1:0]   RST_VALID_LIFETIME = 16'd1000;
    localparam logic [TTL_W-1:0]   RST_FIRST_WAIT     = 16'd5;
    localparam logic [TTL_W-1:0]   RST_RETRY_WAIT     = 16'd50;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT    = 4'd3;

    // one word of the entry memory
    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [TTL_W-1:0]   ttl;
        logic [RETRY_W-1:0] retries;
    } t_entry;

endpackage

// File: src/arp_cache_with_aging_unit.sv
// arp cache with aging: lookup, learn and tick sequencer over one entry memory
// depends on arpc_pkg and assert_macros.svh
//
//  channel   signals                                    handshake
//  -------   -----------------------------------------  -------------------
//  request   i_kind, i_target_ip, i_learned_mac          i_valid / o_ready
//  result    o_status, o_found_mac, o_request_ip,        o_valid / i_ready
//            o_entry_index, o_last
//  config    i_cfg_idx, i_cfg_data                       i_cfg_we, no wait
//
//  a resolve or learn request walks every entry: each entry gets a memory read step and
//  an evaluate step of the shared compare/decrement unit, then, once the output register
//  is free, a finish step writes the chosen entry, if any, and emits the result
//  a tick takes the same walk; each retry result waits for the output register
//  o_ready is high only while the sequencer is idle; a finished result may still
//  sit in the output register while the next request is taken
//  reset clears the entry state flags only; address, mac, lifetime and retry words
//  of a free entry are never read and are rewritten whenever an entry is claimed
`include "assert_macros.svh"

module arp_cache_with_aging_unit #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [arpc_pkg::KIND_W-1:0]      i_kind,
    input  logic [arpc_pkg::IP_W-1:0]        i_target_ip,
    input  logic [arpc_pkg::MAC_W-1:0]       i_learned_mac,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [arpc_pkg::STATUS_W-1:0]    o_status,
    output logic [arpc_pkg::MAC_W-1:0]       o_found_mac,
    output logic [arpc_pkg::IP_W-1:0]        o_request_ip,
    output logic [arpc_pkg::EIDX_W-1:0]      o_entry_index,
    output logic                             o_last,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // configuration registers
    logic [arpc_pkg::TTL_W-1:0]   r_valid_lifetime;
    logic [arpc_pkg::TTL_W-1:0]   r_first_wait;
    logic [arpc_pkg::TTL_W-1:0]   r_retry_wait;
    logic [arpc_pkg::RETRY_W-1:0] r_retry_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_lifetime <= arpc_pkg::RST_VALID_LIFETIME;
            r_first_wait     <= arpc_pkg::RST_FIRST_WAIT;
            r_retry_wait     <= arpc_pkg::RST_RETRY_WAIT;
            r_retry_limit    <= arpc_pkg::RST_RETRY_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arpc_pkg::CFG_VALID_LIFETIME: r_valid_lifetime <= i_cfg_data;
                arpc_pkg::CFG_FIRST_WAIT:     r_first_wait     <= i_cfg_data;
                arpc_pkg::CFG_RETRY_WAIT:     r_retry_wait     <= i_cfg_data;
                arpc_pkg::CFG_RETRY_LIMIT:
                    r_retry_limit <= i_cfg_data[arpc_pkg::RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // entry memory, one read and one write port, registered read data
    arpc_pkg::t_entry r_mem [TABLE_DEPTH];
    arpc_pkg::t_entry r_rd_word;
    logic             mem_we;
    logic [IW-1:0]    mem_addr;
    arpc_pkg::t_entry mem_wdata;

    // entry state flags, cleared at reset
    logic [1:0] r_ent_st [TABLE_DEPTH];
    logic       st_we;
    logic [IW-1:0] st_addr;
    logic [1:0] st_wdata;

    // sequencer and request registers
    logic [1:0]                    r_fsm, n_fsm;
    logic [IW-1:0]                 r_idx, n_idx;
    logic [arpc_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [arpc_pkg::IP_W-1:0]     r_ip, n_ip;
    logic [arpc_pkg::MAC_W-1:0]    r_mac, n_mac;

    // search results
    logic                          r_hit, n_hit;
    logic [IW-1:0]                 r_hit_idx, n_hit_idx;
    logic                          r_hit_valid, n_hit_valid;
    logic [arpc_pkg::MAC_W-1:0]    r_hit_mac, n_hit_mac;
    logic                          r_free, n_free;
    logic [IW-1:0]                 r_free_idx, n_free_idx;

    // output register
    logic                          r_out_vld;
    logic [arpc_pkg::STATUS_W-1:0] r_out_status;
    logic [arpc_pkg::MAC_W-1:0]    r_out_mac;
    logic [arpc_pkg::IP_W-1:0]     r_out_ip;
    logic [arpc_pkg::EIDX_W-1:0]   r_out_idx;
    logic                          r_out_last;

    logic                          out_load;
    logic                          emit;
    logic [arpc_pkg::STATUS_W-1:0] em_status;
    logic [arpc_pkg::MAC_W-1:0]    em_mac;
    logic [arpc_pkg::IP_W-1:0]     em_ip;
    logic [IW-1:0]                 em_idx;
    logic                          em_last;
    logic [IW+2:0]                 em_idx_ext;

    // shared compare/decrement unit
    logic [1:0]                    cur_st;
    logic                          ip_eq;
    logic [arpc_pkg::TTL_W-1:0]    ttl_dec;

    assign cur_st  = r_ent_st[r_idx];
    assign ip_eq   = (r_rd_word.ip == r_ip);
    assign ttl_dec = (r_rd_word.ttl != '0) ? (r_rd_word.ttl - 1'b1) : r_rd_word.ttl;

    assign out_load   = !r_out_vld || i_ready;
    assign em_idx_ext = {3'b000, em_idx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_word <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_ent_st[k] <= arpc_pkg::ENT_FREE;
            end
        end else if (st_we) begin
            r_ent_st[st_addr] <= st_wdata;
        end
    end

    always_comb begin
        n_fsm       = r_fsm;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_valid = r_hit_valid;
        n_hit_mac   = r_hit_mac;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        mem_we      = 1'b0;
        mem_addr    = r_idx;
        mem_wdata   = r_rd_word;
        st_we       = 1'b0;
        st_addr     = r_idx;
        st_wdata    = arpc_pkg::ENT_FREE;
        emit        = 1'b0;
        em_status   = arpc_pkg::STAT_TICK_DONE;
        em_mac      = '0;
        em_ip       = '0;
        em_idx      = '0;
        em_last     = 1'b0;

        case (r_fsm)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = i_kind;
                    n_ip   = i_target_ip;
                    n_mac  = i_learned_mac;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    // unused kind is taken and dropped
                    if (i_kind != arpc_pkg::KIND_NONE) begin
                        n_fsm = S_RD;
                    end
                end
            end

            S_RD: begin
                n_fsm = S_EV;
            end

            S_EV: begin
                logic advance;
                advance = 1'b1;
                if (r_kind == arpc_pkg::KIND_TICK) begin
                    if (cur_st != arpc_pkg::ENT_FREE) begin
                        if (ttl_dec != '0) begin
                            mem_we        = 1'b1;
                            mem_wdata.ttl = ttl_dec;
                        end else if (cur_st == arpc_pkg::ENT_PENDING) begin
                            if (r_rd_word.retries != '0) begin
                                // reissue: wait until the output register is free
                                advance = out_load;
                                if (out_load) begin
                                    mem_we            = 1'b1;
                                    mem_wdata.ttl     = r_retry_wait;
                                    mem_wdata.retries = r_rd_word.retries - 1'b1;
                                    emit              = 1'b1;
                                    em_status         = arpc_pkg::STAT_RETRY_REQ;
                                    em_ip             = r_rd_word.ip;
                                    em_idx            = r_idx;
                                end
                            end else begin
                                st_we = 1'b1;
                            end
                        end else if (cur_st == arpc_pkg::ENT_VALID) begin
                            st_we = 1'b1;
                        end else begin
                            // unknown state code: lifetime just runs down
                            mem_we        = 1'b1;
                            mem_wdata.ttl = ttl_dec;
                        end
                    end
                end else begin
                    // lowest matching occupied entry and lowest free entry
                    if (cur_st != arpc_pkg::ENT_FREE && ip_eq && !r_hit) begin
                        n_hit       = 1'b1;
                        n_hit_idx   = r_idx;
                        n_hit_valid = (cur_st == arpc_pkg::ENT_VALID);
                        n_hit_mac   = r_rd_word.mac;
                    end
                    if (cur_st == arpc_pkg::ENT_FREE && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_idx;
                    end
                end
                if (advance) begin
                    if (r_idx == LAST_IDX) begin
                        n_fsm = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_fsm = S_RD;
                    end
                end
            end

            S_FIN: begin
                if (out_load) begin
                    emit    = 1'b1;
                    em_last = 1'b1;
                    n_fsm   = S_IDLE;
                    case (r_kind)
                        arpc_pkg::KIND_RESOLVE: begin
                            if (r_hit) begin
                                em_idx = r_hit_idx;
                                if (r_hit_valid) begin
                                    em_status = arpc_pkg::STAT_HIT;
                                    em_mac    = r_hit_mac;
                                end else begin
                                    em_status = arpc_pkg::STAT_PENDING;
                                end
                            end else if (r_free) begin
                                mem_we            = 1'b1;
                                mem_addr          = r_free_idx;
                                mem_wdata.ip      = r_ip;
                                mem_wdata.mac     = '0;
                                mem_wdata.ttl     = r_first_wait;
                                mem_wdata.retries = r_retry_limit;
                                st_we             = 1'b1;
                                st_addr           = r_free_idx;
                                st_wdata          = arpc_pkg::ENT_PENDING;
                                em_status         = arpc_pkg::STAT_NEW_REQ;
                                em_ip             = r_ip;
                                em_idx            = r_free_idx;
                            end else begin
                                em_status = arpc_pkg::STAT_FULL;
                            end
                        end
                        arpc_pkg::KIND_LEARN: begin
                            if (r_hit || r_free) begin
                                mem_we            = 1'b1;
                                mem_addr          = r_hit ? r_hit_idx : r_free_idx;
                                mem_wdata.ip      = r_ip;
                                mem_wdata.mac     = r_mac;
                                mem_wdata.ttl     = r_valid_lifetime;
                                mem_wdata.retries = '0;
                                st_we             = 1'b1;
                                st_addr           = mem_addr;
                                st_wdata          = arpc_pkg::ENT_VALID;
                                em_status         = arpc_pkg::STAT_LEARNED;
                                em_idx            = mem_addr;
                            end else begin
                                em_status = arpc_pkg::STAT_FULL;
                            end
                        end
                        default: begin
                            em_status = arpc_pkg::STAT_TICK_DONE;
                        end
                    endcase
                end
            end

            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_fsm  <= n_fsm;
            r_idx  <= n_idx;
            r_hit  <= n_hit;
            r_free <= n_free;
            if (out_load) begin
                r_out_vld <= emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_ip        <= n_ip;
        r_mac       <= n_mac;
        r_hit_idx   <= n_hit_idx;
        r_hit_valid <= n_hit_valid;
        r_hit_mac   <= n_hit_mac;
        r_free_idx  <= n_free_idx;
        if (out_load && emit) begin
            r_out_status <= em_status;
            r_out_mac    <= em_mac;
            r_out_ip     <= em_ip;
            r_out_idx    <= em_idx_ext[2:0];
            r_out_last   <= em_last;
        end
    end

    assign o_ready       = (r_fsm == S_IDLE);
    assign o_valid       = r_out_vld;
    assign o_status      = r_out_status;
    assign o_found_mac   = r_out_mac;
    assign o_request_ip  = r_out_ip;
    assign o_entry_index = r_out_idx;
    assign o_last        = r_out_last;

    // a retry result is never the final one of a tick
    `ASSERT_RST(a_retry_not_last, i_clk, i_rst_n, (o_valid && o_status == arpc_pkg::STAT_RETRY_REQ) |-> !o_last)
    // the finish step only follows a full walk
    `ASSERT_RST(a_fin_at_end, i_clk, i_rst_n, (r_fsm == S_FIN) |-> (r_idx == LAST_IDX))
    // the entry memory is written only while evaluating or finishing
    `ASSERT_RST(a_mem_we_phase, i_clk, i_rst_n, mem_we |-> (r_fsm == S_EV || r_fsm == S_FIN))
    // a real request starts the walk at the first entry
    `ASSERT_RST(a_walk_start, i_clk, i_rst_n, (i_valid && o_ready && i_kind != arpc_pkg::KIND_NONE) |=> (r_fsm == S_RD && r_idx == '0))

endmodule

// File: dv/arp_cache_with_aging_unit_tb.sv
// self-checking testbench for arp_cache_with_aging_unit: directed table, then random phases
// depends on arpc_pkg and the unit under test, nothing else
`timescale 1ns / 1ps

module arp_cache_with_aging_unit_tb;

    import arpc_pkg::*;

    localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH;  // covers one full table walk plus slack
    localparam int STALL_LIMIT  = 3000;             // cycles with no handshake before giving up
    localparam int HOLD_CYCLES  = 300;              // long result back-pressure stretch
    localparam int IDLE_PCT     = 31;
    localparam int PHASE_ITEMS  = 20;
    localparam int POOL_SIZE    = 10;               // more addresses than entries, so full shows up
    localparam int N_DIRECTED   = 21;

    // one result beat as the block presents it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MAC_W-1:0]    mac;
        logic [IP_W-1:0]     ip;
        logic [EIDX_W-1:0]   idx;
        logic                last;
    } arp_result_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        bit                typed;
        arp_result_t       want;
    } stim_row_t;

    typedef enum int {PH_MIN, PH_MID, PH_ZERO, PH_MAX} phase_e;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [KIND_W-1:0]     i_kind;
    logic [IP_W-1:0]       i_target_ip;
    logic [MAC_W-1:0]      i_learned_mac;
    logic                  o_valid;
    logic                  i_ready;
    logic [STATUS_W-1:0]   o_status;
    logic [MAC_W-1:0]      o_found_mac;
    logic [IP_W-1:0]       o_request_ip;
    logic [EIDX_W-1:0]     o_entry_index;
    logic                  o_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // typed expectation travels with the request payload
    bit          row_typed;
    arp_result_t row_want;

    // side controls for idling and back-pressure
    bit send_idle_en;
    bit sink_idle_en;
    bit start_hold;

    int n_errors;
    int quiet_cycles;

    // shadow copy of the cache table and its settings
    logic [1:0]         shadow_state   [TABLE_DEPTH];
    logic [IP_W-1:0]    shadow_ip      [TABLE_DEPTH];
    logic [MAC_W-1:0]   shadow_mac     [TABLE_DEPTH];
    logic [TTL_W-1:0]   shadow_ttl     [TABLE_DEPTH];
    logic [RETRY_W-1:0] shadow_retries [TABLE_DEPTH];
    logic [TTL_W-1:0]   cfg_lifetime;
    logic [TTL_W-1:0]   cfg_first_wait;
    logic [TTL_W-1:0]   cfg_retry_wait;
    logic [RETRY_W-1:0] cfg_retry_limit;

    arp_result_t event_results [$];   // results of the request just taken
    arp_result_t replies_due [$];     // results still owed by the block, oldest first

    arp_cache_with_aging_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_target_ip   (i_target_ip),
        .i_learned_mac (i_learned_mac),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_mac   (o_found_mac),
        .o_request_ip  (o_request_ip),
        .o_entry_index (o_entry_index),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic arp_result_t reply(input logic [STATUS_W-1:0] status,
                                          input logic [MAC_W-1:0] mac,
                                          input logic [IP_W-1:0] ip,
                                          input logic [EIDX_W-1:0] idx,
                                          input logic last);
        arp_result_t r;
        r.status = status;
        r.mac    = mac;
        r.ip     = ip;
        r.idx    = idx;
        r.last   = last;
        return r;
    endfunction

    function automatic stim_row_t dir_row(input logic [KIND_W-1:0] kind,
                                          input logic [IP_W-1:0] ip,
                                          input logic [MAC_W-1:0] mac,
                                          input bit typed, input arp_result_t want);
        stim_row_t r;
        r.kind  = kind;
        r.ip    = ip;
        r.mac   = mac;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // lowest occupied entry holding this address, -1 if none
    function automatic int find_slot(input logic [IP_W-1:0] ip);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_state[i] != ENT_FREE && shadow_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // lowest free entry, wiped and tagged with the address; state is left to the caller
    function automatic int claim_slot(input logic [IP_W-1:0] ip);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (shadow_state[i] == ENT_FREE) begin
                shadow_ip[i]      = ip;
                shadow_mac[i]     = '0;
                shadow_ttl[i]     = '0;
                shadow_retries[i] = '0;
                return i;
            end
        end
        return -1;
    endfunction

    // advance the shadow table by one request and collect what the block must answer
    function automatic void apply_arp_event(input logic [KIND_W-1:0] kind,
                                            input logic [IP_W-1:0] ip,
                                            input logic [MAC_W-1:0] mac);
        int e;
        event_results.delete();
        case (kind)
            KIND_RESOLVE: begin
                e = find_slot(ip);
                if (e >= 0) begin
                    // known address: hit when valid, otherwise still waiting for a reply
                    if (shadow_state[e] == ENT_VALID)
                        event_results.push_back(reply(STAT_HIT, shadow_mac[e], '0,
                                                      EIDX_W'(e), 1'b1));
                    else
                        event_results.push_back(reply(STAT_PENDING, '0, '0,
                                                      EIDX_W'(e), 1'b1));
                end else begin
                    e = claim_slot(ip);
                    if (e < 0) begin
                        event_results.push_back(reply(STAT_FULL, '0, '0, '0, 1'b1));
                    end else begin
                        shadow_state[e]   = ENT_PENDING;
                        shadow_retries[e] = cfg_retry_limit;
                        shadow_ttl[e]     = cfg_first_wait;
                        event_results.push_back(reply(STAT_NEW_REQ, '0, ip, EIDX_W'(e), 1'b1));
                    end
                end
            end
            KIND_LEARN: begin
                e = find_slot(ip);
                if (e < 0)
                    e = claim_slot(ip);
                if (e < 0) begin
                    event_results.push_back(reply(STAT_FULL, '0, '0, '0, 1'b1));
                end else begin
                    shadow_mac[e]     = mac;
                    shadow_state[e]   = ENT_VALID;
                    shadow_ttl[e]     = cfg_lifetime;
                    shadow_retries[e] = '0;
                    event_results.push_back(reply(STAT_LEARNED, '0, '0, EIDX_W'(e), 1'b1));
                end
            end
            KIND_TICK: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (shadow_state[i] == ENT_FREE)
                        continue;
                    if (shadow_ttl[i] != '0)
                        shadow_ttl[i] = shadow_ttl[i] - 1'b1;
                    if (shadow_ttl[i] != '0)
                        continue;
                    // lifetime ran out: pending entries retry or give up, valid ones expire
                    if (shadow_state[i] == ENT_PENDING) begin
                        if (shadow_retries[i] != '0) begin
                            shadow_retries[i] = shadow_retries[i] - 1'b1;
                            shadow_ttl[i]     = cfg_retry_wait;
                            event_results.push_back(reply(STAT_RETRY_REQ, '0, shadow_ip[i],
                                                          EIDX_W'(i), 1'b0));
                        end else begin
                            shadow_state[i] = ENT_FREE;
                        end
                    end else if (shadow_state[i] == ENT_VALID) begin
                        shadow_state[i] = ENT_FREE;
                    end
                end
                event_results.push_back(reply(STAT_TICK_DONE, '0, '0, '0, 1'b1));
            end
            default: ;  // unused kind is dropped without a result
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // offer one request at the falling edge and hold it until it is taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IP_W-1:0] ip,
                                input logic [MAC_W-1:0] mac, input bit typed,
                                input arp_result_t want);
        while (send_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_target_ip   <= ip;
        i_learned_mac <= mac;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // writes all four registers back to back, called at a falling edge with the block idle
    task automatic load_settings(input logic [TTL_W-1:0] lifetime, input logic [TTL_W-1:0] first,
                                 input logic [TTL_W-1:0] retry, input logic [RETRY_W-1:0] limit);
        logic [CFG_IDX_W-1:0]  idxs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idxs = '{CFG_VALID_LIFETIME, CFG_FIRST_WAIT, CFG_RETRY_WAIT, CFG_RETRY_LIMIT};
        // unused upper bits of the retry limit word carry junk
        vals = '{lifetime, first, retry,
                 {12'($urandom_range(0, 4095)), limit}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
            @(negedge i_clk);
        end
        i_cfg_we        <= 1'b0;
        cfg_lifetime    = lifetime;
        cfg_first_wait  = first;
        cfg_retry_wait  = retry;
        cfg_retry_limit = limit;
    endtask

    // result sink: random idling, plus one long hold-off when asked for
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (start_hold) begin
                start_hold = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !sink_idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // checker: results are compared first, then the request taken at the same edge is predicted
    always @(posedge i_clk) begin : scoreboard
        arp_result_t got;
        arp_result_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = reply(o_status, o_found_mac, o_request_ip, o_entry_index, o_last);
                if (replies_due.size() == 0) begin
                    report_mismatch($sformatf("result with nothing owed, status %0d",
                                              got.status));
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.mac !== want.mac)
                        report_mismatch($sformatf("found_mac %h, want %h", got.mac, want.mac));
                    if (got.ip !== want.ip)
                        report_mismatch($sformatf("request_ip %h, want %h", got.ip, want.ip));
                    if (got.idx !== want.idx)
                        report_mismatch($sformatf("entry_index %0d, want %0d",
                                                  got.idx, want.idx));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
                end
            end
            if (i_valid && o_ready) begin
                // shadow table always advances; typed rows replace the computed answer
                apply_arp_event(i_kind, i_target_ip, i_learned_mac);
                if (row_typed)
                    replies_due.push_back(row_want);
                else
                    foreach (event_results[k])
                        replies_due.push_back(event_results[k]);
            end
        end
    end

    // watchdog: too long without any handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("arp_cache_with_aging_unit_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        stim_row_t          directed_rows [N_DIRECTED];
        logic [IP_W-1:0]    ip_pool [POOL_SIZE];
        logic [TTL_W-1:0]   lt;
        logic [TTL_W-1:0]   fw;
        logic [TTL_W-1:0]   rw;
        logic [RETRY_W-1:0] rl;
        logic [KIND_W-1:0]  kind;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        phase_e             phase;
        int                 counted;
        int                 pick;
        bit                 paused;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = KIND_NONE;
        i_target_ip   = '0;
        i_learned_mac = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_VALID_LIFETIME;
        i_cfg_data    = '0;
        row_typed     = 1'b0;
        row_want      = '0;
        send_idle_en  = 1'b1;
        sink_idle_en  = 1'b1;
        start_hold    = 1'b0;
        n_errors      = 0;
        quiet_cycles  = 0;

        // shadow table starts empty, settings at their reset values
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_state[i]   = ENT_FREE;
            shadow_ip[i]      = '0;
            shadow_mac[i]     = '0;
            shadow_ttl[i]     = '0;
            shadow_retries[i] = '0;
        end
        cfg_lifetime    = RST_VALID_LIFETIME;
        cfg_first_wait  = RST_FIRST_WAIT;
        cfg_retry_wait  = RST_RETRY_WAIT;
        cfg_retry_limit = RST_RETRY_LIMIT;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short lifetimes so the directed part can age everything out in three ticks
        load_settings(16'd2, 16'd1, 16'd2, 4'd1);

        directed_rows = '{
            // first miss claims entry 0, second lookup finds it still waiting
            dir_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0, 3'd0, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b1,
                    reply(STAT_PENDING, '0, '0, 3'd0, 1'b1)),
            // all-ones address and mac
            dir_row(KIND_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
                    reply(STAT_LEARNED, '0, '0, 3'd1, 1'b1)),
            dir_row(KIND_RESOLVE, 32'hFFFF_FFFF, 48'h0, 1'b1,
                    reply(STAT_HIT, 48'hFFFF_FFFF_FFFF, '0, 3'd1, 1'b1)),
            // reply for a pending entry turns it valid in place
            dir_row(KIND_LEARN, 32'h0, 48'h0, 1'b1,
                    reply(STAT_LEARNED, '0, '0, 3'd0, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b1,
                    reply(STAT_HIT, 48'h0, '0, 3'd0, 1'b1)),
            // unused kind gives nothing back
            dir_row(KIND_NONE, 32'hDEAD_BEEF, 48'h1234_5678_9ABC, 1'b0, '0),
            dir_row(KIND_LEARN, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 1'b1,
                    reply(STAT_LEARNED, '0, '0, 3'd2, 1'b1)),
            // fill the rest of the table with pending entries
            dir_row(KIND_RESOLVE, 32'h0A00_0001, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0A00_0001, 3'd3, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0A00_0002, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0A00_0002, 3'd4, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0A00_0003, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0A00_0003, 3'd5, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0A00_0004, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0A00_0004, 3'd6, 1'b1)),
            dir_row(KIND_RESOLVE, 32'h0A00_0005, 48'h0, 1'b1,
                    reply(STAT_NEW_REQ, '0, 32'h0A00_0005, 3'd7, 1'b1)),
            // table full for both lookup and learn
            dir_row(KIND_RESOLVE, 32'h0102_0304, 48'h0, 1'b1,
                    reply(STAT_FULL, '0, '0, 3'd0, 1'b1)),
            dir_row(KIND_LEARN, 32'h0102_0304, 48'h0123_4567_89AB, 1'b1,
                    reply(STAT_FULL, '0, '0, 3'd0, 1'b1)),
            dir_row(KIND_LEARN, 32'h0A00_0001, 48'h0000_1111_2222, 1'b0, '0),
            // first tick: pending entries retry, then still-pending lookup,
            // then everything expires over the next two ticks
            dir_row(KIND_TICK, 32'h0, 48'h0, 1'b0, '0),
            dir_row(KIND_RESOLVE, 32'h0A00_0002, 48'h0, 1'b0, '0),
            dir_row(KIND_TICK, 32'h5555_AAAA, 48'hAAAA_5555_AAAA, 1'b0, '0),
            dir_row(KIND_TICK, 32'h0, 48'h0, 1'b0, '0),
            // freed entry is claimed again
            dir_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b0, '0)
        };

        foreach (directed_rows[r])
            send_request(directed_rows[r].kind, directed_rows[r].ip, directed_rows[r].mac,
                         directed_rows[r].typed, directed_rows[r].want);

        for (int p = PH_MIN; p <= PH_MAX; p++) begin
            phase = phase_e'(p);

            // settle: nothing owed and the walker done before touching the registers
            i_valid <= 1'b0;
            do @(negedge i_clk); while (replies_due.size() != 0);
            repeat (DRAIN_CYCLES) @(negedge i_clk);

            case (phase)
                PH_MIN: begin
                    lt = 16'd1;  fw = 16'd1;  rw = 16'd1;  rl = 4'd0;
                end
                PH_MID: begin
                    lt = 16'($urandom_range(2, 12));
                    fw = 16'($urandom_range(1, 4));
                    rw = 16'($urandom_range(1, 6));
                    rl = 4'($urandom_range(0, 15));
                end
                PH_ZERO: begin
                    // zero waits: pending entries retry on every tick until retries run out
                    lt = 16'd0;  fw = 16'd0;  rw = 16'd0;
                    rl = 4'($urandom_range(1, 15));
                end
                default: begin
                    // longest settings last, since nothing expires afterwards
                    lt = 16'hFFFF;  fw = 16'hFFFF;  rw = 16'hFFFF;  rl = 4'hF;
                end
            endcase
            load_settings(lt, fw, rw, rl);

            foreach (ip_pool[k])
                ip_pool[k] = $urandom;

            // middle phase runs with no idling on either side, under one long hold-off
            send_idle_en = (phase != PH_MID);
            sink_idle_en = (phase != PH_MID);
            if (phase == PH_MID)
                start_hold = 1'b1;

            counted = 0;
            paused  = 1'b0;
            while (counted < PHASE_ITEMS) begin
                if (phase == PH_MID && !paused && counted == PHASE_ITEMS / 2) begin
                    // sender waits until every owed result is back
                    paused = 1'b1;
                    i_valid <= 1'b0;
                    do @(negedge i_clk); while (replies_due.size() != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = KIND_RESOLVE;
                else if (pick < 65)
                    kind = KIND_LEARN;
                else if (pick < 95)
                    kind = KIND_TICK;
                else
                    kind = KIND_NONE;
                ip  = (kind == KIND_NONE) ? IP_W'($urandom)
                                          : ip_pool[$urandom_range(0, POOL_SIZE - 1)];
                mac = {16'($urandom), 32'($urandom)};
                send_request(kind, ip, mac, 1'b0, '0);
                if (kind != KIND_NONE)
                    counted++;
            end
        end

        i_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("arp_cache_with_aging_unit_tb passed");
        else
            $display("arp_cache_with_aging_unit_tb failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/arpc_pkg.sv
src/arp_cache_with_aging_unit.sv
dv/arp_cache_with_aging_unit_tb.sv
